// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by fraction_reduce_and_min.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication check, disabled while in reset
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
// next-cycle implication check, disabled while in reset
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ===== hw/rtl/frm_pkg.sv =====
// Package for fraction_reduce_and_min: widths and sequencer states.
// No dependencies.
package frm_pkg;
	localparam int VW = 32;
	localparam int DW = VW - 1;
	localparam int CW = $clog2(DW + 1);
	localparam int SW = 2 * VW;
	localparam int MW = ((2 * VW + 2 * DW + 7) / 8) * 8;
	typedef enum logic [3:0] {
		ST_IDLE, ST_GCD_INIT, ST_GCD_DIV, ST_GCD_NEXT,
		ST_DIVN_INIT, ST_DIVN, ST_DIVD_INIT, ST_DIVD,
		ST_MUL1, ST_MUL2, ST_CMP, ST_OUT
	} state_t;
endpackage

// ===== hw/rtl/fraction_reduce_and_min.sv =====
// Channel | dir | tdata fields (low bit first)                      | tuser | tlast
// s_axis  | in  | numerator[31:0], denominator[63:32]               | -     | last_in_list
// m_axis  | out | reduced_num[31:0], reduced_den[62:32],            | zero_den_error | list_done
//         |     | min_num[94:63], min_den[125:95], pad to 128        |       |
// A result passes through the Euclid steps (ST_GCD_INIT, ST_GCD_DIV, ST_GCD_NEXT), the
// two reducing divisions, ST_MUL1, ST_MUL2 and ST_CMP before ST_OUT registers it; a
// zero denominator goes from ST_GCD_INIT straight to ST_OUT.
// One shared restoring divider (one quotient bit per cycle) runs every Euclid
// step and both reducing divisions; one shared 31x31 multiplier forms the cross products.
// Reset clears the sequencer and the running minimum. s_axis_tready is high only
// in idle; a result waits in ST_OUT while the previous one is still held.
// Top level; uses frm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module fraction_reduce_and_min (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [frm_pkg::SW-1:0]  s_axis_tdata,  // numerator, denominator
	input  logic                    s_axis_tlast,  // last_in_list
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [frm_pkg::MW-1:0]  m_axis_tdata,  // reduced_num, reduced_den, min_num, min_den
	output logic                    m_axis_tuser,  // zero_den_error
	output logic                    m_axis_tlast   // list_done
);
	import frm_pkg::*;

	state_t st_q, st_d;
	logic [DW-1:0] nmag_q, dmag_q, a_q, b_q, rem_q, dvd_q, dvs_q;
	logic [CW-1:0] cnt_q;
	logic nneg_q, dneg_q, last_q, err_q;
	logic [VW-1:0] best_num_q;
	logic [DW-1:0] best_den_q;
	logic best_neg_q, have_q;
	logic [2*DW-1:0] p1_q, p2_q;
	logic [MW-1:0] odata_q;
	logic ouser_q, olast_q, ovalid_q;

	logic [VW-1:0] in_n, in_d;
	logic [DW-1:0] in_nm, in_dm, rnm, rdn;
	logic rneg, less, out_fire;
	logic [DW:0] trial;
	logic [VW-1:0] rnum;
	logic [DW-1:0] mul_a, mul_b;
	logic [2*DW-1:0] prod;

	function automatic logic [DW-1:0] sat_mag(input logic [VW-1:0] v);
		logic [VW-1:0] m;
		m = v[VW-1] ? (~v + 1'b1) : v;
		sat_mag = m[VW-1] ? {DW{1'b1}} : m[DW-1:0];
	endfunction

	assign in_n = s_axis_tdata[VW-1:0];
	assign in_d = s_axis_tdata[2*VW-1:VW];
	assign in_nm = sat_mag(in_n);
	assign in_dm = sat_mag(in_d);
	assign trial = {rem_q, dvd_q[DW-1]} - {1'b0, dvs_q};
	assign rnm = nmag_q;
	assign rdn = dmag_q;
	assign rneg = (rnm != '0) && (nneg_q != dneg_q);
	assign rnum = rneg ? (~{1'b0, rnm} + 1'b1) : {1'b0, rnm};
	// p1 = new*best_den, p2 = best*new_den
	assign mul_a = (st_q == ST_MUL1) ? nmag_q : sat_mag(best_num_q);
	assign mul_b = (st_q == ST_MUL1) ? best_den_q : dmag_q;
	assign prod = (2*DW)'(mul_a) * (2*DW)'(mul_b);
	always_comb begin
		if (rneg != best_neg_q) less = rneg;
		else if (!rneg) less = p1_q < p2_q;
		else less = p2_q < p1_q;
	end

	assign out_fire = (st_q == ST_OUT) && (!ovalid_q || m_axis_tready);
	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = ouser_q;
	assign m_axis_tlast = olast_q;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (s_axis_tvalid) st_d = ST_GCD_INIT;
			ST_GCD_INIT: st_d = err_q ? ST_OUT : (b_q == '0 ? ST_DIVN_INIT : ST_GCD_DIV);
			ST_GCD_DIV: if (cnt_q == CW'(1)) st_d = ST_GCD_NEXT;
			ST_GCD_NEXT: st_d = (rem_q == '0) ? ST_DIVN_INIT : ST_GCD_DIV;
			ST_DIVN_INIT: st_d = ST_DIVN;
			ST_DIVN: if (cnt_q == CW'(1)) st_d = ST_DIVD_INIT;
			ST_DIVD_INIT: st_d = ST_DIVD;
			ST_DIVD: if (cnt_q == CW'(1)) st_d = ST_MUL1;
			ST_MUL1: st_d = ST_MUL2;
			ST_MUL2: st_d = ST_CMP;
			ST_CMP: st_d = ST_OUT;
			ST_OUT: if (!ovalid_q || m_axis_tready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// datapath; shared restoring divider dvd / dvs: quotient in dvd_q, remainder in rem_q
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (s_axis_tvalid) begin
				nmag_q <= in_nm;
				dmag_q <= in_dm;
				nneg_q <= in_n[VW-1];
				dneg_q <= in_d[VW-1];
				last_q <= s_axis_tlast;
				err_q <= (in_dm == '0);
				a_q <= in_nm;
				b_q <= in_dm;
			end
			ST_GCD_INIT: begin
				// a mod b: divide a by b
				dvd_q <= a_q;
				dvs_q <= b_q;
				rem_q <= '0;
				cnt_q <= CW'(DW);
				if (b_q == '0) a_q <= a_q;
			end
			ST_GCD_DIV, ST_DIVN, ST_DIVD: begin
				rem_q <= trial[DW] ? {rem_q[DW-2:0], dvd_q[DW-1]} : trial[DW-1:0];
				dvd_q <= {dvd_q[DW-2:0], ~trial[DW]};
				cnt_q <= cnt_q - 1'b1;
				if (st_q == ST_DIVN && cnt_q == CW'(1))
					nmag_q <= {dvd_q[DW-2:0], ~trial[DW]};
				if (st_q == ST_DIVD && cnt_q == CW'(1))
					dmag_q <= {dvd_q[DW-2:0], ~trial[DW]};
			end
			ST_GCD_NEXT: begin
				a_q <= b_q;
				b_q <= rem_q;
				dvd_q <= b_q;
				dvs_q <= rem_q;
				rem_q <= '0;
				cnt_q <= CW'(DW);
			end
			ST_DIVN_INIT: begin
				dvd_q <= nmag_q;
				dvs_q <= (b_q == '0) ? a_q : b_q;
				rem_q <= '0;
				cnt_q <= CW'(DW);
			end
			ST_DIVD_INIT: begin
				dvd_q <= dmag_q;
				rem_q <= '0;
				cnt_q <= CW'(DW);
			end
			ST_MUL1: p1_q <= prod;
			ST_MUL2: p2_q <= prod;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
			best_num_q <= '0;
			best_den_q <= '0;
			best_neg_q <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			if (out_fire) ovalid_q <= 1'b1;
			else if (m_axis_tready) ovalid_q <= 1'b0;
			if (st_q == ST_CMP && (!have_q || less)) begin
				have_q <= 1'b1;
				best_num_q <= rnum;
				best_den_q <= rdn;
				best_neg_q <= rneg;
			end
			if (out_fire && last_q) begin
				have_q <= 1'b0;
				best_num_q <= '0;
				best_den_q <= '0;
				best_neg_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_fire) begin
			odata_q <= MW'({have_q ? best_den_q : DW'(0), have_q ? best_num_q : VW'(0),
				err_q ? DW'(0) : rdn, err_q ? VW'(0) : rnum});
			ouser_q <= err_q;
			olast_q <= last_q;
		end
	end

	`ASSERT_IMP(a_busy_not_ready, st_q != ST_IDLE, !s_axis_tready)
	`ASSERT_NXT(a_accept_starts, s_axis_tvalid && s_axis_tready, st_q == ST_GCD_INIT)
	`ASSERT_IMP(a_err_den_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[VW+DW-1:VW] == '0)
endmodule
